/* hw/rtl/impt_pkg.sv */
// Shared types, constants and codes of the indexed max-priority table.
package impt_pkg;

   localparam int CAPACITY       = 16;
   localparam int VALUE_WIDTH    = 32;
   localparam int PRIORITY_WIDTH = 16;
   localparam int STAMP_WIDTH    = 32;
   localparam int IDX_W          = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      MODE_ADD     = 3'd0,
      MODE_PROMOTE = 3'd1,
      MODE_POP     = 3'd2,
      MODE_LOOKUP  = 3'd3,
      MODE_PEEK    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_BADSLOT = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] value_in;
      logic [3:0]  slot_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_out;
      logic [31:0] value_out;
      logic [15:0] priority_out;
      logic        present;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic scan;
      logic execute;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } stat_type;

endpackage

/* hw/rtl/impt_ctrl.sv */
// Controller state machine of the indexed max-priority table.
module impt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  impt_pkg::stat_type stat,
   output impt_pkg::cmd_type  cmd
);
   import impt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               state_in = stat.need_scan ? CTL_SCAN : CTL_EXEC;
            end
         end
         CTL_SCAN: begin
            if (stat.scan_last) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         CTL_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         CTL_SCAN: begin
            cmd.scan = 1'b1;
         end
         CTL_EXEC: begin
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* hw/rtl/impt_dp.sv */
// Datapath of the indexed max-priority table: slot storage, max scan, result word.
module impt_dp (
   input  logic               clock,
   input  logic               reset,
   input  impt_pkg::req_type  req_data,
   input  impt_pkg::cmd_type  cmd,
   output impt_pkg::stat_type stat,
   output logic               rsp_strobe,
   output impt_pkg::rsp_type  rsp_data
);
   import impt_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   logic [VALUE_WIDTH-1:0]    vals_ff  [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] prios_ff [CAPACITY];
   logic [STAMP_WIDTH-1:0]    stamps_ff[CAPACITY];
   logic [CAPACITY-1:0]       valid_ff;
   logic [STAMP_WIDTH-1:0]    next_stamp_ff;

   req_type                   req_ff;
   logic [IDX_W-1:0]          scan_idx_ff;
   logic                      best_found_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [PRIORITY_WIDTH-1:0] best_prio_ff;
   logic [STAMP_WIDTH-1:0]    best_stamp_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      rsp_strobe_ff;

   logic                      req_is_scan;
   logic [IDX_W-1:0]          rd_idx;
   logic [VALUE_WIDTH-1:0]    rd_val;
   logic [PRIORITY_WIDTH-1:0] rd_prio;
   logic [STAMP_WIDTH-1:0]    rd_stamp;
   logic                      rd_valid;
   logic                      take_best;

   logic                      free_found;
   logic [IDX_W-1:0]          free_idx;
   logic [PRIORITY_WIDTH-1:0] prio_inc;

   logic                      wr_add;
   logic                      wr_prio;
   logic                      clr_valid;
   logic [IDX_W-1:0]          wr_idx;

   assign stat.need_scan = (req_data.mode == MODE_POP) || (req_data.mode == MODE_PEEK);
   assign stat.scan_last = (scan_idx_ff == LAST_IDX);
   assign req_is_scan    = (req_ff.mode == MODE_POP) || (req_ff.mode == MODE_PEEK);

   // single read port: scan index, winning slot, or addressed slot
   always_comb begin
      if (cmd.scan) begin
         rd_idx = scan_idx_ff;
      end else if (req_is_scan) begin
         rd_idx = best_idx_ff;
      end else begin
         rd_idx = req_ff.slot_in[IDX_W-1:0];
      end
   end

   assign rd_val   = vals_ff[rd_idx];
   assign rd_prio  = prios_ff[rd_idx];
   assign rd_stamp = stamps_ff[rd_idx];
   assign rd_valid = valid_ff[rd_idx];

   // higher priority wins, later stamp breaks a tie
   assign take_best = rd_valid && (!best_found_ff || (rd_prio > best_prio_ff) ||
                      ((rd_prio == best_prio_ff) && (rd_stamp > best_stamp_ff)));

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign prio_inc = (rd_prio == '1) ? rd_prio : rd_prio + PRIORITY_WIDTH'(1);

   // execute step: result word and table updates
   always_comb begin
      rsp_in    = '0;
      wr_add    = 1'b0;
      wr_prio   = 1'b0;
      clr_valid = 1'b0;
      wr_idx    = rd_idx;
      unique case (req_ff.mode)
         MODE_ADD: begin
            if (!free_found || (next_stamp_ff == '1)) begin
               rsp_in.status = STAT_FULL;
            end else begin
               wr_add              = cmd.execute;
               wr_idx              = free_idx;
               rsp_in.status       = STAT_OK;
               rsp_in.slot_out     = 4'(free_idx);
               rsp_in.value_out    = 32'(req_ff.value_in[VALUE_WIDTH-1:0]);
               rsp_in.present      = 1'b1;
            end
         end
         MODE_PROMOTE, MODE_LOOKUP: begin
            rsp_in.slot_out = req_ff.slot_in;
            if (!rd_valid) begin
               rsp_in.status = STAT_BADSLOT;
            end else begin
               rsp_in.status    = STAT_OK;
               rsp_in.value_out = 32'(rd_val);
               rsp_in.present   = 1'b1;
               if (req_ff.mode == MODE_PROMOTE) begin
                  wr_prio             = cmd.execute;
                  rsp_in.priority_out = 16'(prio_inc);
               end else begin
                  rsp_in.priority_out = 16'(rd_prio);
               end
            end
         end
         MODE_POP, MODE_PEEK: begin
            if (!best_found_ff) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               clr_valid           = cmd.execute && (req_ff.mode == MODE_POP);
               rsp_in.status       = STAT_OK;
               rsp_in.slot_out     = 4'(best_idx_ff);
               rsp_in.value_out    = 32'(rd_val);
               rsp_in.priority_out = 16'(rd_prio);
               rsp_in.present      = 1'b1;
            end
         end
         default: begin
            rsp_in.status = STAT_OK;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         next_stamp_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         best_found_ff <= 1'b0;
         scan_idx_ff   <= '0;
      end else begin
         rsp_strobe_ff <= cmd.execute;
         if (cmd.capture) begin
            scan_idx_ff   <= '0;
            best_found_ff <= 1'b0;
         end else if (cmd.scan) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            if (take_best) begin
               best_found_ff <= 1'b1;
            end
         end
         if (wr_add) begin
            valid_ff[wr_idx] <= 1'b1;
            next_stamp_ff    <= next_stamp_ff + STAMP_WIDTH'(1);
         end
         if (clr_valid) begin
            valid_ff[wr_idx] <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.scan && take_best) begin
         best_idx_ff   <= scan_idx_ff;
         best_prio_ff  <= rd_prio;
         best_stamp_ff <= rd_stamp;
      end
      if (wr_add) begin
         vals_ff[wr_idx]   <= req_ff.value_in[VALUE_WIDTH-1:0];
         prios_ff[wr_idx]  <= '0;
         stamps_ff[wr_idx] <= next_stamp_ff;
      end
      if (wr_prio) begin
         prios_ff[wr_idx] <= prio_inc;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* hw/rtl/indexed_max_priority_table.sv */
// Top level of the indexed max-priority table: controller plus datapath.
//
// Usage:
//   A request word is taken on req_data at a rising edge where start is high
//   and busy is low. Modes: add, promote, pop max, lookup slot, peek max.
//   Each request yields exactly one response word on rsp_data, shown for one
//   cycle with rsp_strobe high. The receiver cannot hold responses off, so
//   sample rsp_data whenever rsp_strobe is high.
//
// Timing:
//   Add, promote, lookup and unused modes: accept leads straight to the
//   execute step, whose result is registered and shown with the strobe;
//   the next word can be accepted in the strobe cycle. Pop and peek walk
//   every slot of the table one slot per cycle through the single read
//   port of the datapath, then run the execute step.
//
// Reset (synchronous, active high): clear all valid bits and the stamp
// counter, drop any word in flight, return the controller to idle. Slot
// contents are not cleared; only valid slots are ever reported.
module indexed_max_priority_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  impt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output impt_pkg::rsp_type rsp_data
);
   import impt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence capture, scan and execute steps
   impt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // hold the table, run the max scan, register the response word
   impt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
